/* sv/arfd_pkg.sv */
// Shared types, codes and constants of the animation RLE 24-bit frame decoder.
package arfd_pkg;

  localparam int MAX_RUN   = 128;
  localparam int IN_DEPTH  = 2;
  localparam int IN_AW     = $clog2(IN_DEPTH);
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);

  localparam logic [15:0] HDR_EXTENDED   = 16'h0008;
  localparam logic [7:0]  CODE_NEXT_LINE = 8'hFF;
  localparam logic [7:0]  ALPHA_OPAQUE   = 8'hFF;
  localparam logic [24:0] OFF_CAP        = 25'h100_0000;
  localparam logic [23:0] BYTE_INDEX_MAX = 24'hFF_FFFF;
  localparam logic [15:0] LINE_COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_CHUNK_BYTES  = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    PH_HDR_HI = 4'd0,
    PH_HDR_LO = 4'd1,
    PH_SKL_HI = 4'd2,
    PH_SKL_LO = 4'd3,
    PH_PAD1A  = 4'd4,
    PH_PAD1B  = 4'd5,
    PH_NL_HI  = 4'd6,
    PH_NL_LO  = 4'd7,
    PH_PAD2A  = 4'd8,
    PH_PAD2B  = 4'd9,
    PH_SKIP   = 4'd10,
    PH_CODE   = 4'd11,
    PH_RED    = 4'd12,
    PH_GREEN  = 4'd13,
    PH_BLUE   = 4'd14
  } phase_t;

  // One compressed byte together with its run code decoding.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       is_zero;
    logic       is_next_line;
    logic       is_literal;
    logic [7:0] len;
    logic [9:0] len3;
  } byte_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [23:0] offset;
    logic [7:0]  length;
    logic [31:0] word;
    logic        last;
  } result_t;

  // Up to two results written into the result queue in one cycle.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } res_push_t;

  function automatic logic [24:0] off_cap(input logic [28:0] s);
    return (s > 29'(OFF_CAP)) ? OFF_CAP : s[24:0];
  endfunction

endpackage

/* sv/arfd_front.sv */
// Front part: accepts compressed bytes, decodes the run code fields and queues them.
module arfd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           data_byte,
  input  logic                 chunk_start,
  output logic                 item_valid,
  input  logic                 item_ready,
  output arfd_pkg::byte_item_t item
);

  localparam int AW = arfd_pkg::IN_AW;

  arfd_pkg::byte_item_t slot [arfd_pkg::IN_DEPTH];
  arfd_pkg::byte_item_t incoming;
  logic [AW-1:0]        head;
  logic [AW-1:0]        tail;
  logic [AW:0]          count;
  logic                 enq;
  logic                 deq;

  always_comb begin
    incoming.data         = data_byte;
    incoming.start        = chunk_start;
    incoming.is_zero      = (data_byte == 8'd0);
    incoming.is_next_line = (data_byte == arfd_pkg::CODE_NEXT_LINE);
    incoming.is_literal   = !data_byte[7];
    // A negative code repeats one pixel minus-code times.
    incoming.len          = data_byte[7] ? (8'd0 - data_byte) : data_byte;
    incoming.len3         = {1'b0, incoming.len, 1'b0} + {2'b00, incoming.len};
  end

  assign full       = (count == (AW+1)'(arfd_pkg::IN_DEPTH));
  assign item_valid = (count != '0);
  assign item       = slot[head];
  assign enq        = push && !full;
  assign deq        = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (enq) begin
      slot[tail] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (enq) begin
        tail <= tail + AW'(1);
      end
      if (deq) begin
        head <= head + AW'(1);
      end
      count <= count + (AW+1)'(enq) - (AW+1)'(deq);
    end
  end

endmodule

/* sv/arfd_back.sv */
// Back part: configuration registers and the chunk parser that turns bytes into results.
module arfd_back #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [23:0]          cfg_data,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  arfd_pkg::byte_item_t item,
  input  logic                 out_room,
  output arfd_pkg::res_push_t  res
);

  localparam logic [12:0] RESET_WIDTH  = 13'd640;
  localparam logic [12:0] RESET_HEIGHT = 13'd480;

  typedef struct packed {
    arfd_pkg::phase_t phase;
    logic [23:0]      byte_index;
    logic [15:0]      word_hold;
    logic [15:0]      lines_to_decode;
    logic [15:0]      line_count;
    logic [24:0]      line_base;
    logic [24:0]      write_offset;
    logic             run_literal;
    logic [7:0]       pixels_left;
    logic [15:0]      color_hold;
    logic             frame_finished;
  } parse_t;

  localparam parse_t PARSE_IDLE = '{phase: arfd_pkg::PH_HDR_HI, frame_finished: 1'b1,
                                    default: '0};

  function automatic logic [12:0] clamp_width(input logic [12:0] w);
    return (w > MAX_WIDTH) ? 13'(MAX_WIDTH) : w;
  endfunction

  logic [12:0] eff_width;
  logic [12:0] frame_height;
  logic [23:0] chunk_bytes;
  logic [24:0] frame_end;
  logic [12:0] cfg_width_in;

  parse_t      parse;
  parse_t      parse_next;
  parse_t      base;
  logic [28:0] skip_product;
  logic        skip_load;
  logic [15:0] hold_word;

  logic        fire;
  logic        active;
  logic [7:0]  b;
  logic [23:0] bi_inc;
  logic [15:0] lc_inc;
  logic [24:0] next_line_base;
  logic [24:0] skip_offset;
  logic        run_too_far;
  logic        lit_short;
  logic [7:0]  pl_dec;
  logic        done;
  logic        err;
  logic        pix;
  logic [7:0]  pix_len;
  logic [31:0] word;
  arfd_pkg::result_t pix_res;
  arfd_pkg::result_t status_res;
  logic        has_status;

  assign cfg_width_in = clamp_width(cfg_data[12:0]);

  // The frame end is kept as a product so that run checks need only an add and compare.
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_width    <= clamp_width(RESET_WIDTH);
      frame_height <= RESET_HEIGHT;
      chunk_bytes  <= '0;
      frame_end    <= arfd_pkg::off_cap(29'(clamp_width(RESET_WIDTH)) * 29'(RESET_HEIGHT));
    end else if (cfg_write) begin
      case (cfg_index)
        arfd_pkg::REG_FRAME_WIDTH: begin
          eff_width <= cfg_width_in;
          frame_end <= arfd_pkg::off_cap(29'(cfg_width_in) * 29'(frame_height));
        end
        arfd_pkg::REG_FRAME_HEIGHT: begin
          frame_height <= cfg_data[12:0];
          frame_end    <= arfd_pkg::off_cap(29'(eff_width) * 29'(cfg_data[12:0]));
        end
        arfd_pkg::REG_CHUNK_BYTES: begin
          chunk_bytes <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  assign item_ready = out_room;
  assign fire       = item_valid && out_room;

  always_comb begin
    b      = item.data;
    active = item.start || !parse.frame_finished;
    base   = parse;
    if (item.start) begin
      // A chunk start drops the current frame and begins from a cleared state.
      base       = '0;
      base.phase = arfd_pkg::PH_HDR_HI;
    end
    parse_next = base;
    bi_inc = (base.byte_index != arfd_pkg::BYTE_INDEX_MAX) ?
             base.byte_index + 24'd1 : base.byte_index;
    parse_next.byte_index = bi_inc;
    lc_inc = (base.line_count != arfd_pkg::LINE_COUNT_MAX) ?
             base.line_count + 16'd1 : base.line_count;
    hold_word      = {base.word_hold[15:8], b};
    next_line_base = arfd_pkg::off_cap(29'(base.line_base) + 29'(eff_width));
    skip_offset    = arfd_pkg::off_cap(29'(base.write_offset) + 29'(b) - 29'd1);
    run_too_far    = (26'(base.write_offset) + 26'(item.len)) > 26'(frame_end);
    lit_short      = (26'(bi_inc) + 26'(item.len3)) >= 26'(chunk_bytes);
    pl_dec         = (base.pixels_left != 8'd0) ? base.pixels_left - 8'd1 : 8'd0;
    word           = {arfd_pkg::ALPHA_OPAQUE, base.color_hold, b};
    done      = 1'b0;
    err       = 1'b0;
    pix       = 1'b0;
    pix_len   = 8'd0;
    skip_load = 1'b0;

    case (base.phase)
      arfd_pkg::PH_HDR_HI: begin
        parse_next.word_hold = {b, 8'd0};
        parse_next.phase     = arfd_pkg::PH_HDR_LO;
      end
      arfd_pkg::PH_SKL_HI: begin
        parse_next.word_hold = {b, 8'd0};
        parse_next.phase     = arfd_pkg::PH_SKL_LO;
      end
      arfd_pkg::PH_NL_HI: begin
        parse_next.word_hold = {b, 8'd0};
        parse_next.phase     = arfd_pkg::PH_NL_LO;
      end
      arfd_pkg::PH_HDR_LO: begin
        parse_next.word_hold = hold_word;
        if (hold_word == arfd_pkg::HDR_EXTENDED) begin
          parse_next.phase = arfd_pkg::PH_SKL_HI;
        end else begin
          parse_next.lines_to_decode = {3'b000, frame_height};
          parse_next.line_count      = '0;
          parse_next.line_base       = '0;
          parse_next.write_offset    = '0;
          parse_next.phase           = arfd_pkg::PH_SKIP;
        end
      end
      arfd_pkg::PH_SKL_LO: begin
        // The skipped-line product is registered here and capped on the next byte.
        parse_next.word_hold = hold_word;
        skip_load            = 1'b1;
        parse_next.phase     = arfd_pkg::PH_PAD1A;
      end
      arfd_pkg::PH_PAD1A: begin
        parse_next.line_base    = arfd_pkg::off_cap(skip_product);
        parse_next.write_offset = arfd_pkg::off_cap(skip_product);
        parse_next.phase        = arfd_pkg::PH_PAD1B;
      end
      arfd_pkg::PH_PAD1B: begin
        parse_next.phase = arfd_pkg::PH_NL_HI;
      end
      arfd_pkg::PH_NL_LO: begin
        parse_next.word_hold       = hold_word;
        parse_next.lines_to_decode = hold_word;
        parse_next.line_count      = '0;
        parse_next.phase           = arfd_pkg::PH_PAD2A;
      end
      arfd_pkg::PH_PAD2A: begin
        parse_next.phase = arfd_pkg::PH_PAD2B;
      end
      arfd_pkg::PH_PAD2B: begin
        parse_next.phase = arfd_pkg::PH_SKIP;
      end
      arfd_pkg::PH_SKIP: begin
        if (b == 8'd0 || base.line_count >= base.lines_to_decode) begin
          done = 1'b1;
        end else begin
          parse_next.write_offset = skip_offset;
          parse_next.phase        = arfd_pkg::PH_CODE;
        end
      end
      arfd_pkg::PH_CODE: begin
        if (item.is_zero) begin
          parse_next.phase = arfd_pkg::PH_SKIP;
        end else if (item.is_next_line) begin
          parse_next.line_count = lc_inc;
          if (lc_inc >= base.lines_to_decode) begin
            done = 1'b1;
          end else begin
            parse_next.line_base    = next_line_base;
            parse_next.write_offset = next_line_base;
            parse_next.phase        = arfd_pkg::PH_SKIP;
          end
        end else if (run_too_far) begin
          err = 1'b1;
        end else if (item.is_literal && lit_short) begin
          err = 1'b1;
        end else begin
          parse_next.run_literal = item.is_literal;
          parse_next.pixels_left = item.len;
          parse_next.phase       = arfd_pkg::PH_RED;
        end
      end
      arfd_pkg::PH_RED: begin
        parse_next.color_hold = {b, 8'd0};
        parse_next.phase      = arfd_pkg::PH_GREEN;
      end
      arfd_pkg::PH_GREEN: begin
        parse_next.color_hold = {base.color_hold[15:8], b};
        parse_next.phase      = arfd_pkg::PH_BLUE;
      end
      arfd_pkg::PH_BLUE: begin
        pix = 1'b1;
        if (base.run_literal) begin
          pix_len                 = 8'd1;
          parse_next.write_offset = arfd_pkg::off_cap(29'(base.write_offset) + 29'd1);
          parse_next.pixels_left  = pl_dec;
          parse_next.phase        = (pl_dec == 8'd0) ? arfd_pkg::PH_CODE : arfd_pkg::PH_RED;
        end else begin
          pix_len = (base.pixels_left > arfd_pkg::MAX_RUN) ?
                    8'(arfd_pkg::MAX_RUN) : base.pixels_left;
          parse_next.write_offset = arfd_pkg::off_cap(29'(base.write_offset) + 29'(pix_len));
          parse_next.pixels_left  = '0;
          parse_next.phase        = arfd_pkg::PH_CODE;
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase

    if (!done && !err && bi_inc >= chunk_bytes) begin
      err = 1'b1;
    end
    if (done || err) begin
      parse_next.frame_finished = 1'b1;
    end

    pix_res.kind   = arfd_pkg::KIND_PIXEL;
    pix_res.offset = base.write_offset[23:0];
    pix_res.length = pix_len;
    pix_res.word   = word;
    pix_res.last   = !(done || err);

    status_res.kind   = done ? arfd_pkg::KIND_DONE : arfd_pkg::KIND_ERROR;
    status_res.offset = '0;
    status_res.length = '0;
    status_res.word   = '0;
    status_res.last   = 1'b1;

    res.first  = pix ? pix_res : status_res;
    res.second = status_res;
    if (fire && active) begin
      res.count = 2'(pix) + 2'(done || err);
    end else begin
      res.count = 2'd0;
    end
    has_status = (res.count == 2'd2) ||
                 (res.count == 2'd1 && res.first.kind != arfd_pkg::KIND_PIXEL);
  end

  always_ff @(posedge clk) begin
    if (fire && active && skip_load) begin
      skip_product <= 29'(hold_word) * 29'(eff_width);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse <= PARSE_IDLE;
    end else if (fire && active) begin
      parse <= parse_next;
    end
  end

  a_status_ends_frame: assert property (@(posedge clk) disable iff (rst)
    has_status |=> parse.frame_finished)
    else $error("status result did not close the frame");

  a_results_need_room: assert property (@(posedge clk) disable iff (rst)
    (res.count != 2'd0) |-> (item_valid && out_room))
    else $error("results produced without a taken byte or queue room");

endmodule

/* sv/arfd_result_queue.sv */
// Result queue: takes up to two results a cycle from the parser and hands out one at a time.
module arfd_result_queue (
  input  logic                clk,
  input  logic                rst,
  input  arfd_pkg::res_push_t wr,
  output logic                room,
  input  logic                pop,
  output logic                empty,
  output arfd_pkg::result_t   head
);

  localparam int AW = arfd_pkg::OUT_AW;

  arfd_pkg::result_t slot [arfd_pkg::OUT_DEPTH];
  logic [AW-1:0]     rd_ptr;
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     wr_ptr_1;
  logic [AW:0]       count;
  logic              do_pop;

  assign room     = (count <= (AW+1)'(arfd_pkg::OUT_DEPTH - 2));
  assign empty    = (count == '0);
  assign head     = slot[rd_ptr];
  assign do_pop   = pop && !empty;
  assign wr_ptr_1 = wr_ptr + AW'(1);

  always_ff @(posedge clk) begin
    if (wr.count != 2'd0) begin
      slot[wr_ptr] <= wr.first;
    end
    if (wr.count == 2'd2) begin
      slot[wr_ptr_1] <= wr.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(wr.count);
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + (AW+1)'(wr.count) - (AW+1)'(do_pop);
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(arfd_pkg::OUT_DEPTH))
    else $error("result queue count beyond its depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (wr.count != 2'd0) |-> (int'(count) + int'(wr.count) <= arfd_pkg::OUT_DEPTH))
    else $error("result queue written beyond its free space");

endmodule

/* sv/animation_rle24_frame_decoder_core.sv */
// Top level of the animation RLE 24-bit frame decoder: byte queue, parser and result queue.
// Path: byte queue register, combinational parser, result queue register, then the output ports.
// Throughput: one byte per cycle while the result queue has room, set by the parser; a byte
// with a pixel and a status result takes two pops, absorbed by the four-entry result queue.
// Reset (synchronous): both queues empty, parser idle until a chunk start, registers
// frame_width 640, frame_height 480, chunk_bytes 0.
module animation_rle24_frame_decoder_core #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        chunk_start,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind,
  output logic [23:0] start_offset,
  output logic [7:0]  run_length,
  output logic [31:0] pixel_word,
  output logic        last_of_run,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  arfd_pkg::byte_item_t item;
  logic                 item_valid;
  logic                 item_ready;
  arfd_pkg::res_push_t  res;
  logic                 out_room;
  arfd_pkg::result_t    head;

  arfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .data_byte   (data_byte),
    .chunk_start (chunk_start),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item)
  );

  arfd_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_room   (out_room),
    .res        (res)
  );

  arfd_result_queue u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (res),
    .room  (out_room),
    .pop   (pop),
    .empty (empty),
    .head  (head)
  );

  assign result_kind  = head.kind;
  assign start_offset = head.offset;
  assign run_length   = head.length;
  assign pixel_word   = head.word;
  assign last_of_run  = head.last;

endmodule

/* bench/animation_rle24_frame_decoder_core_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the animation RLE 24-bit frame decoder core.
module animation_rle24_frame_decoder_core_test;

  localparam int WIDTH_CAP     = 4096;
  localparam int RANDOM_ITEMS  = 900;
  localparam int CALM_AFTER    = 750;
  localparam int SETTLE_CYCLES = 10;
  localparam int LIMIT_CYCLES  = 600000;
  localparam int PRINT_CAP     = 100;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } chunk_byte_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'h00;
  logic        chunk_start = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  result_kind;
  logic [23:0] start_offset;
  logic [7:0]  run_length;
  logic [31:0] pixel_word;
  logic        last_of_run;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;

  animation_rle24_frame_decoder_core DUT (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .chunk_start  (chunk_start),
    .empty        (empty),
    .pop          (pop),
    .result_kind  (result_kind),
    .start_offset (start_offset),
    .run_length   (run_length),
    .pixel_word   (pixel_word),
    .last_of_run  (last_of_run),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stimulus and expected write commands.
  chunk_byte_t       byte_queue [$];
  chunk_byte_t       staged [$];
  logic [7:0]        frame_buf [$];
  arfd_pkg::result_t expected_cmds [$];
  arfd_pkg::result_t want_cmd;

  int   mismatches = 0;
  int   cycles = 0;
  int   send_gap = 0;
  int   pop_gap = 0;
  logic calm = 1'b0;

  // Decoder state as the testbench sees it.
  logic [12:0]      cur_width;
  logic [12:0]      cur_height;
  logic [23:0]      cur_bytes;
  arfd_pkg::phase_t st_phase = arfd_pkg::PH_HDR_HI;
  logic [23:0]      consumed = '0;
  logic [15:0]      word_acc = '0;
  logic [15:0]      lines_target = '0;
  logic [15:0]      lines_done = '0;
  logic [24:0]      row_base = '0;
  logic [24:0]      pen = '0;
  logic [7:0]       code_reg = '0;
  logic [7:0]       pix_left = '0;
  logic [15:0]      rg_acc = '0;
  logic             idle_state = 1'b1;

  function automatic logic [24:0] clamp_offset(input logic [39:0] s);
    return (s > 40'(arfd_pkg::OFF_CAP)) ? arfd_pkg::OFF_CAP : s[24:0];
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic start);
    arfd_pkg::result_t cmd_buf [2];
    int          n;
    logic        fin_done;
    logic        fin_err;
    logic [12:0] fw;
    logic [7:0]  len;
    logic [31:0] word;
    n = 0;
    fin_done = 1'b0;
    fin_err = 1'b0;
    fw = (cur_width > 13'(WIDTH_CAP)) ? 13'(WIDTH_CAP) : cur_width;
    if (start) begin
      st_phase = arfd_pkg::PH_HDR_HI;
      consumed = '0;
      word_acc = '0;
      lines_target = '0;
      lines_done = '0;
      row_base = '0;
      pen = '0;
      code_reg = '0;
      pix_left = '0;
      rg_acc = '0;
      idle_state = 1'b0;
    end else if (idle_state) begin
      return;
    end
    if (consumed < arfd_pkg::BYTE_INDEX_MAX) consumed++;

    case (st_phase)
      arfd_pkg::PH_HDR_HI, arfd_pkg::PH_SKL_HI, arfd_pkg::PH_NL_HI: begin
        word_acc = {b, 8'h00};
        st_phase = arfd_pkg::phase_t'(st_phase + 1);
      end
      arfd_pkg::PH_HDR_LO: begin
        word_acc = {word_acc[15:8], b};
        if (word_acc == arfd_pkg::HDR_EXTENDED) begin
          st_phase = arfd_pkg::PH_SKL_HI;
        end else begin
          lines_target = 16'(cur_height);
          lines_done = '0;
          row_base = '0;
          pen = '0;
          st_phase = arfd_pkg::PH_SKIP;
        end
      end
      arfd_pkg::PH_SKL_LO: begin
        word_acc = {word_acc[15:8], b};
        row_base = clamp_offset(40'(word_acc) * 40'(fw));
        pen = row_base;
        st_phase = arfd_pkg::PH_PAD1A;
      end
      arfd_pkg::PH_NL_LO: begin
        word_acc = {word_acc[15:8], b};
        lines_target = word_acc;
        lines_done = '0;
        st_phase = arfd_pkg::PH_PAD2A;
      end
      arfd_pkg::PH_PAD1A, arfd_pkg::PH_PAD1B, arfd_pkg::PH_PAD2A: begin
        st_phase = arfd_pkg::phase_t'(st_phase + 1);
      end
      arfd_pkg::PH_PAD2B: begin
        st_phase = arfd_pkg::PH_SKIP;
      end
      arfd_pkg::PH_SKIP: begin
        if (b == 8'h00 || lines_done >= lines_target) begin
          fin_done = 1'b1;
        end else begin
          pen = clamp_offset(40'(pen) + 40'(b) - 40'd1);
          st_phase = arfd_pkg::PH_CODE;
        end
      end
      arfd_pkg::PH_CODE: begin
        if (b == 8'h00) begin
          st_phase = arfd_pkg::PH_SKIP;
        end else if (b == arfd_pkg::CODE_NEXT_LINE) begin
          if (lines_done != arfd_pkg::LINE_COUNT_MAX) lines_done++;
          if (lines_done >= lines_target) begin
            fin_done = 1'b1;
          end else begin
            row_base = clamp_offset(40'(row_base) + 40'(fw));
            pen = row_base;
            st_phase = arfd_pkg::PH_SKIP;
          end
        end else begin
          len = b[7] ? 8'(9'd256 - 9'(b)) : b;
          if (40'(pen) + 40'(len) > 40'(clamp_offset(40'(fw) * 40'(cur_height)))) begin
            fin_err = 1'b1;
          end else if (!b[7] && 40'(consumed) + 40'(len) * 40'd3 >= 40'(cur_bytes)) begin
            // Literal pixels plus at least one more byte must fit in the chunk.
            fin_err = 1'b1;
          end else begin
            code_reg = b;
            pix_left = len;
            st_phase = arfd_pkg::PH_RED;
          end
        end
      end
      arfd_pkg::PH_RED: begin
        rg_acc = {b, 8'h00};
        st_phase = arfd_pkg::PH_GREEN;
      end
      arfd_pkg::PH_GREEN: begin
        rg_acc = {rg_acc[15:8], b};
        st_phase = arfd_pkg::PH_BLUE;
      end
      arfd_pkg::PH_BLUE: begin
        word = {arfd_pkg::ALPHA_OPAQUE, rg_acc[15:8], rg_acc[7:0], b};
        if (!code_reg[7]) begin
          cmd_buf[n] = '{arfd_pkg::KIND_PIXEL, pen[23:0], 8'd1, word, 1'b0};
          n++;
          pen = clamp_offset(40'(pen) + 40'd1);
          if (pix_left != 0) pix_left--;
          st_phase = (pix_left == 0) ? arfd_pkg::PH_CODE : arfd_pkg::PH_RED;
        end else begin
          len = (pix_left > 8'(arfd_pkg::MAX_RUN)) ? 8'(arfd_pkg::MAX_RUN) : pix_left;
          cmd_buf[n] = '{arfd_pkg::KIND_PIXEL, pen[23:0], len, word, 1'b0};
          n++;
          pen = clamp_offset(40'(pen) + 40'(len));
          pix_left = '0;
          st_phase = arfd_pkg::PH_CODE;
        end
      end
      default: begin
        fin_err = 1'b1;
      end
    endcase

    if (!fin_done && !fin_err && consumed >= cur_bytes) fin_err = 1'b1;
    if (fin_done) begin
      cmd_buf[n] = '{arfd_pkg::KIND_DONE, 24'd0, 8'd0, 32'd0, 1'b0};
      n++;
    end else if (fin_err) begin
      cmd_buf[n] = '{arfd_pkg::KIND_ERROR, 24'd0, 8'd0, 32'd0, 1'b0};
      n++;
    end
    if (fin_done || fin_err) idle_state = 1'b1;
    if (n > 0) cmd_buf[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_cmds.push_back(cmd_buf[i]);
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Monitor: both handshakes are sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        decode_byte(data_byte, chunk_start);
        void'(byte_queue.pop_front());
      end
      if (pop && !empty) begin
        if (expected_cmds.size() == 0) begin
          flag_mismatch("result with nothing expected", 32'(result_kind), 32'd0);
        end else begin
          want_cmd = expected_cmds.pop_front();
          if (result_kind !== want_cmd.kind)
            flag_mismatch("result_kind", 32'(result_kind), 32'(want_cmd.kind));
          if (start_offset !== want_cmd.offset)
            flag_mismatch("start_offset", 32'(start_offset), 32'(want_cmd.offset));
          if (run_length !== want_cmd.length)
            flag_mismatch("run_length", 32'(run_length), 32'(want_cmd.length));
          if (pixel_word !== want_cmd.word)
            flag_mismatch("pixel_word", pixel_word, want_cmd.word);
          if (last_of_run !== want_cmd.last)
            flag_mismatch("last_of_run", 32'(last_of_run), 32'(want_cmd.last));
        end
      end
    end
  end

  // Byte driver with random idle bursts.
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (send_gap != 0) begin
      send_gap--;
      push <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      send_gap = $urandom_range(0, 16);
      push <= 1'b0;
    end else if (byte_queue.size() != 0) begin
      push <= 1'b1;
      data_byte <= byte_queue[0].data;
      chunk_start <= byte_queue[0].start;
    end else begin
      push <= 1'b0;
    end
  end

  // Result consumer with random stall bursts.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_gap != 0) begin
      pop_gap--;
      pop <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      pop_gap = $urandom_range(0, 16);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic set_regs(input logic [12:0] w, input logic [12:0] h,
                          input logic [23:0] nbytes);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= arfd_pkg::REG_FRAME_WIDTH;
    cfg_data <= 24'(w);
    cur_width = w;
    @(negedge clk);
    cfg_index <= arfd_pkg::REG_FRAME_HEIGHT;
    cfg_data <= 24'(h);
    cur_height = h;
    @(negedge clk);
    cfg_index <= arfd_pkg::REG_CHUNK_BYTES;
    cfg_data <= nbytes;
    cur_bytes = nbytes;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic stage_frame();
    foreach (frame_buf[i]) staged.push_back({frame_buf[i], i == 0});
  endtask

  // Hands the staged bytes to the driver, then holds off until every result is in.
  task automatic run_staged();
    foreach (staged[i]) byte_queue.push_back(staged[i]);
    staged.delete();
    while (byte_queue.size() != 0 || expected_cmds.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_skip();
    if ($urandom_range(0, 19) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(1, 4));
  endfunction

  // Builds one mostly well-formed frame chunk into frame_buf.
  task automatic build_frame(input logic [12:0] lines, input logic far);
    int         runs;
    int         n;
    int         sel;
    logic [15:0] hdr;
    frame_buf.delete();
    if (far || $urandom_range(0, 1) == 1) begin
      frame_buf.push_back(arfd_pkg::HDR_EXTENDED[15:8]);
      frame_buf.push_back(arfd_pkg::HDR_EXTENDED[7:0]);
      if (far) hdr = 16'hFFFF;
      else if ($urandom_range(0, 9) == 0) hdr = 16'($urandom);
      else hdr = 16'($urandom_range(0, 3));
      frame_buf.push_back(hdr[15:8]);
      frame_buf.push_back(hdr[7:0]);
      frame_buf.push_back(8'($urandom));
      frame_buf.push_back(8'($urandom));
      if ($urandom_range(0, 9) == 0) hdr = 16'($urandom);
      else hdr = 16'($urandom_range(0, int'(lines) + 1));
      frame_buf.push_back(hdr[15:8]);
      frame_buf.push_back(hdr[7:0]);
      frame_buf.push_back(8'($urandom));
      frame_buf.push_back(8'($urandom));
    end else begin
      hdr = 16'($urandom);
      frame_buf.push_back(hdr[15:8]);
      frame_buf.push_back(hdr[7:0]);
    end
    frame_buf.push_back(pick_skip());
    runs = $urandom_range(2, 10);
    for (int r = 0; r < runs; r++) begin
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        frame_buf.push_back(8'h00);
        frame_buf.push_back(pick_skip());
      end else if (sel < 22) begin
        frame_buf.push_back(arfd_pkg::CODE_NEXT_LINE);
        frame_buf.push_back(pick_skip());
      end else if (sel < 58) begin
        n = ($urandom_range(0, 49) == 0) ? $urandom_range(4, 127) : $urandom_range(1, 3);
        frame_buf.push_back(8'(n));
        for (int p = 0; p < 3 * n; p++) frame_buf.push_back(8'($urandom));
      end else begin
        n = ($urandom_range(0, 19) == 0) ? arfd_pkg::MAX_RUN : $urandom_range(2, 16);
        frame_buf.push_back(8'(256 - n));
        for (int p = 0; p < 3; p++) frame_buf.push_back(8'($urandom));
      end
    end
    // A zero code followed by a zero skip byte closes the frame.
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h00);
    if ($urandom_range(0, 5) == 0)
      frame_buf[$urandom_range(0, frame_buf.size() - 1)] = 8'($urandom);
  endtask

  initial begin
    int          phase_no;
    int          nchunks;
    int          maxlen;
    int          random_count;
    int          sel;
    int          k;
    logic [12:0] w;
    logic [12:0] h;
    logic [23:0] nbytes;

    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = arfd_pkg::REG_FRAME_WIDTH;
    cfg_data = 24'd0;
    cur_width = 13'd640;
    cur_height = 13'd480;
    cur_bytes = 24'd0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Reset registers: an idle byte is ignored, and a zero chunk size fails at once.
    staged.push_back({8'h55, 1'b0});
    staged.push_back({8'hFF, 1'b1});
    run_staged();

    // Extended header, literal and repeat runs, next line, then a run past the frame end.
    frame_buf = '{8'h00, 8'h08, 8'h00, 8'h00, 8'hAA, 8'h55, 8'h00, 8'h02, 8'h00, 8'h00,
                  8'h02, 8'h01, 8'hFF, 8'h00, 8'h80, 8'hFE, 8'h12, 8'h34, 8'h56, 8'hFF,
                  8'h01, 8'h80};
    stage_frame();
    staged.push_back({8'h7F, 1'b0});
    // Plain header followed by a zero skip byte ends the frame.
    frame_buf = '{8'h12, 8'h34, 8'h00};
    stage_frame();
    set_regs(13'd4, 13'd2, 24'd24);
    run_staged();

    phase_no = 0;
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      calm = (random_count >= CALM_AFTER) || ($urandom_range(0, 4) == 0);
      if (phase_no == 0) begin
        w = 13'd1;
        h = 13'd1;
      end else if (phase_no == 1) begin
        w = 13'h1FFF;
        h = 13'd4096;
      end else begin
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          w = 13'd4096;
          h = 13'h1FFF;
        end else if (sel == 1) begin
          w = 13'($urandom_range(1, 8191));
          h = 13'($urandom_range(1, 8191));
        end else begin
          w = 13'($urandom_range(1, 64));
          h = 13'($urandom_range(1, 32));
        end
      end
      nchunks = $urandom_range(1, 3);
      maxlen = 0;
      if ($urandom_range(0, 3) == 0) staged.push_back({8'($urandom), 1'b0});
      for (int c = 0; c < nchunks; c++) begin
        build_frame(h, phase_no == 1 && c == 0);
        // Cut a chunk short now and then so the next one restarts mid-frame.
        if (c < nchunks - 1 && $urandom_range(0, 4) == 0) begin
          k = $urandom_range(1, frame_buf.size());
          while (frame_buf.size() > k) void'(frame_buf.pop_back());
        end
        if (frame_buf.size() > maxlen) maxlen = frame_buf.size();
        random_count += frame_buf.size();
        stage_frame();
        if ($urandom_range(0, 3) == 0) begin
          k = $urandom_range(1, 3);
          for (int j = 0; j < k; j++) staged.push_back({8'($urandom), 1'b0});
        end
      end
      sel = $urandom_range(0, 19);
      if (sel < 14) nbytes = 24'(maxlen + $urandom_range(0, 3));
      else if (sel < 17) nbytes = 24'($urandom_range(0, maxlen));
      else if (sel < 19) nbytes = 24'hFF_FFFF;
      else nbytes = 24'($urandom_range(0, 255));
      set_regs(w, h, nbytes);
      run_staged();
      phase_no++;
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
